[hw/rtl/cpsl_pkg.sv]
// ----------------------------------------------------------------------------
// cpsl_pkg
// Shared types and constants for the control polygon segment length block.
// ----------------------------------------------------------------------------
package cpsl_pkg;

  localparam int CoordW = 32;
  localparam int IdxW   = 16;
  localparam int LenW   = 34;
  localparam int TotW   = 48;
  localparam int SqW    = 66;

  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;
  localparam logic [CfgIdxW-1:0] CFG_RATIONAL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TOTAL    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FIRST    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQ,
    ST_SQRT,
    ST_FIN,
    ST_OUT
  } cpsl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input transaction
    logic div_start;  // start division of current axis
    logic sq_step;    // accumulate square of one axis
    logic sqrt_start; // init root iteration
    logic sqrt_step;  // one root bit
    logic finish;     // form result, update state
    logic [1:0] axis;
  } cpsl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic rational;
    logic have_prev;
  } cpsl_sts_t;

endpackage

[hw/rtl/cpsl_ctrl.sv]
// ----------------------------------------------------------------------------
// cpsl_ctrl
// Sequencer: projection per axis, squares, root, result hand-off.
// ----------------------------------------------------------------------------
module cpsl_ctrl
  import cpsl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output cpsl_cmd_t cmd,
  input  cpsl_sts_t sts
);

  cpsl_state_t state_r, state_nxt;
  logic [1:0]  axis_r, axis_nxt;
  logic        divgo_r, divgo_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= '0;
      divgo_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      divgo_r <= divgo_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    divgo_nxt = 1'b0;
    cmd       = '0;
    cmd.axis  = axis_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          axis_nxt  = '0;
          divgo_nxt = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!sts.rational) begin
          state_nxt = sts.have_prev ? ST_SQ : ST_FIN;
        end else if (divgo_r) begin
          cmd.div_start = 1'b1;
        end else if (sts.div_done) begin
          if (axis_r == 2'd2) begin
            axis_nxt  = '0;
            state_nxt = sts.have_prev ? ST_SQ : ST_FIN;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            divgo_nxt = 1'b1;
          end
        end
      end
      ST_SQ: begin
        cmd.sq_step = 1'b1;
        if (axis_r == 2'd2) begin
          axis_nxt  = '0;
          state_nxt = ST_SQRT;
          cmd.sqrt_start = 1'b1;
        end else begin
          axis_nxt = axis_r + 2'd1;
        end
      end
      ST_SQRT: begin
        if (sts.sqrt_done) state_nxt = ST_FIN;
        else cmd.sqrt_step = 1'b1;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = sts.have_prev ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE)
    else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("ready while result pending");

endmodule

[hw/rtl/cpsl_dp.sv]
// ----------------------------------------------------------------------------
// cpsl_dp
// Datapath: restoring divider, squared distance, bitwise root, total.
// ----------------------------------------------------------------------------
module cpsl_dp
  import cpsl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cpsl_cmd_t                cmd,
  output cpsl_sts_t                sts,
  input  logic                     cfg_we,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [CfgDataW-1:0]      cfg_data,
  input  logic signed [CoordW-1:0] in_x,
  input  logic signed [CoordW-1:0] in_y,
  input  logic signed [CoordW-1:0] in_z,
  input  logic [CoordW-1:0]        in_w,
  input  logic                     in_last,
  output logic [IdxW-1:0]          o_index,
  output logic [LenW-1:0]          o_len,
  output logic [TotW-1:0]          o_tot,
  output logic                     o_final,
  output logic                     o_ovf
);

  localparam int DivW = CoordW + 16; // dividend magnitude width
  localparam int DivCntW = $clog2(DivW + 1);
  localparam int SqCntW  = $clog2(LenW + 1);

  logic rat_r, tot_en_r;
  logic [IdxW-1:0] first_r;

  logic signed [CoordW-1:0] c_r [3];
  logic signed [CoordW-1:0] p_r [3];
  logic [CoordW-1:0] w_r;
  logic last_r, sat_r, psat_r, havep_r;
  logic [TotW-1:0] run_r;
  logic [IdxW-1:0] cnt_r;

  // divider
  logic [DivW-1:0]   dq_r;
  logic [CoordW:0]   drem_r;
  logic [DivCntW-1:0] dcnt_r;
  logic              dbusy_r, dneg_r;
  // squares / root
  logic [SqW-1:0]    acc_r;
  logic [LenW-1:0]   root_r;
  logic [SqCntW-1:0] scnt_r;
  logic [IdxW-1:0]   oidx_r;
  logic [LenW-1:0]   olen_r;
  logic [TotW-1:0]   otot_r;
  logic              ofin_r, oovf_r;

  logic signed [CoordW-1:0] cur;
  logic [CoordW-1:0] mag;
  logic [CoordW+1:0] trial;
  logic [CoordW:0]   dd;
  logic [CoordW:0]   dmag;
  logic [2*CoordW+1:0] sq;
  logic [LenW-1:0]   cand;
  logic [2*LenW-1:0] cand_sq;
  logic [TotW:0]     tsum;
  logic [CoordW:0]   qlim;
  logic              qsat;

  assign cur  = c_r[cmd.axis];
  assign mag  = cur[CoordW-1] ? CoordW'(-cur) : cur;
  assign trial = {drem_r, dq_r[DivW-1]} - {2'b00, w_r};
  assign dd   = {cur[CoordW-1], cur} - {p_r[cmd.axis][CoordW-1], p_r[cmd.axis]};
  assign dmag = dd[CoordW] ? -dd : dd;
  assign sq   = {{(CoordW+1){1'b0}}, dmag} * {{(CoordW+1){1'b0}}, dmag};
  assign cand = root_r | (LenW'(1) << (scnt_r - 1'b1));
  assign cand_sq = {{LenW{1'b0}}, cand} * {{LenW{1'b0}}, cand};
  assign tsum = {1'b0, run_r} + {{(TotW-LenW+1){1'b0}}, root_r};
  assign qlim = dneg_r ? {2'b01, {(CoordW-1){1'b0}}} : {2'b0, {(CoordW-1){1'b1}}};
  assign qsat = (dq_r[DivW-1:CoordW] != '0) || ({1'b0, dq_r[CoordW-1:0]} > qlim);

  assign sts.div_done  = !dbusy_r;
  assign sts.sqrt_done = (scnt_r == '0);
  assign sts.rational  = rat_r;
  assign sts.have_prev = havep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rat_r <= 1'b0; tot_en_r <= 1'b0; first_r <= '0;
      havep_r <= 1'b0; psat_r <= 1'b0; run_r <= '0; cnt_r <= '0;
      dbusy_r <= 1'b0;
      for (int i = 0; i < 3; i++) p_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RATIONAL: rat_r    <= cfg_data[0];
          CFG_TOTAL:    tot_en_r <= cfg_data[0];
          CFG_FIRST:    first_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.div_start) begin
        dbusy_r <= (w_r != '0);
        dq_r    <= {mag, 16'b0};
        drem_r  <= '0;
        dcnt_r  <= DivCntW'(DivW);
        dneg_r  <= cur[CoordW-1];
        if (w_r == '0) begin
          sat_r <= 1'b1;
          c_r[cmd.axis] <= cur[CoordW-1] ? {1'b1, {(CoordW-1){1'b0}}} :
                           (cur == '0 ? '0 : {1'b0, {(CoordW-1){1'b1}}});
        end
      end else if (dbusy_r) begin
        if (dcnt_r != '0) begin
          dcnt_r <= dcnt_r - 1'b1;
          if (!trial[CoordW+1]) begin
            drem_r <= trial[CoordW:0];
            dq_r   <= {dq_r[DivW-2:0], 1'b1};
          end else begin
            drem_r <= {drem_r[CoordW-1:0], dq_r[DivW-1]};
            dq_r   <= {dq_r[DivW-2:0], 1'b0};
          end
        end else begin
          dbusy_r <= 1'b0;
          if (qsat) sat_r <= 1'b1;
          c_r[cmd.axis] <= qsat ? qlim[CoordW-1:0] :
                           (dneg_r ? -dq_r[CoordW-1:0] : dq_r[CoordW-1:0]);
        end
      end
      if (cmd.finish) begin
        if (havep_r) begin
          oidx_r <= first_r + cnt_r;
          olen_r <= root_r;
          ofin_r <= last_r;
          oovf_r <= sat_r || psat_r || (tot_en_r && tsum[TotW] && root_r != '0);
          otot_r <= '0;
          if (tot_en_r) begin
            run_r  <= tsum[TotW] ? '1 : tsum[TotW-1:0];
            otot_r <= tsum[TotW] ? '1 : tsum[TotW-1:0];
          end
          cnt_r <= cnt_r + 1'b1;
        end
        for (int i = 0; i < 3; i++) p_r[i] <= c_r[i];
        psat_r  <= sat_r;
        havep_r <= 1'b1;
        if (last_r) begin
          havep_r <= 1'b0; psat_r <= 1'b0; run_r <= '0; cnt_r <= '0;
        end
      end
    end
    // payload, no reset
    if (cmd.load) begin
      c_r[0] <= in_x; c_r[1] <= in_y; c_r[2] <= in_z;
      w_r <= in_w; last_r <= in_last; sat_r <= 1'b0;
      acc_r <= '0;
    end
    if (cmd.sq_step) acc_r <= acc_r + SqW'(sq);
    if (cmd.sqrt_start) begin
      root_r <= '0;
      scnt_r <= SqCntW'(LenW);
    end else if (cmd.sqrt_step) begin
      if (cand_sq <= {2'b00, acc_r}) root_r <= cand;
      scnt_r <= scnt_r - 1'b1;
    end
  end

  assign o_index = oidx_r;
  assign o_len   = olen_r;
  assign o_tot   = otot_r;
  assign o_final = ofin_r;
  assign o_ovf   = oovf_r;

endmodule

[hw/rtl/control_polygon_segment_lengths.sv]
// ----------------------------------------------------------------------------
// control_polygon_segment_lengths
// Unsigned Q18.16 distances between consecutive (optionally rational) curve poles.
// ----------------------------------------------------------------------------
// One pole is taken per transaction and processed alone. Steps per pole: a
// load; in rational mode three restoring divisions by the weight, each with
// start, 48 quotient bits, write-back and hand-off (shorter for a zero
// weight), otherwise the divisions are skipped; for poles after the first,
// squaring of the three axes and a bit-serial square root; a finish step;
// then the result is held until taken. The first pole of a run and
// single-pole runs give no result transaction. Configuration writes take
// effect at once; write only between poles.
module control_polygon_segment_lengths
  import cpsl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CfgIdxW-1:0]        cfg_index,
  input  logic [CfgDataW-1:0]       cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [CoordW-1:0]  in_coord_x,
  input  logic signed [CoordW-1:0]  in_coord_y,
  input  logic signed [CoordW-1:0]  in_coord_z,
  input  logic [CoordW-1:0]         in_weight,
  input  logic                      in_last_pole,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IdxW-1:0]           out_segment_index,
  output logic [LenW-1:0]           out_segment_length,
  output logic [TotW-1:0]           out_total_length,
  output logic                      out_final_segment,
  output logic                      out_overflow_flag
);

  cpsl_cmd_t cmd;
  cpsl_sts_t sts;

  cpsl_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .cmd, .sts
  );

  cpsl_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_we, .cfg_index, .cfg_data,
    .in_x(in_coord_x), .in_y(in_coord_y), .in_z(in_coord_z),
    .in_w(in_weight), .in_last(in_last_pole),
    .o_index(out_segment_index), .o_len(out_segment_length),
    .o_tot(out_total_length), .o_final(out_final_segment),
    .o_ovf(out_overflow_flag)
  );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the control polygon segment length block: poles go
// in over valid/ready, a local fixed-point predictor computes each segment,
// and every result transaction is compared with all its fields, in order.
// ----------------------------------------------------------------------------
module tb;
  import cpsl_pkg::*;

  localparam int MaxErrShown = 10;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [LenW-1:0] len;
    logic [TotW-1:0] tot;
    logic            fin;
    logic            ovf;
  } seg_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CoordW-1:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic [CoordW-1:0] in_weight = '0;
  logic in_last_pole = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IdxW-1:0] out_segment_index;
  logic [LenW-1:0] out_segment_length;
  logic [TotW-1:0] out_total_length;
  logic out_final_segment, out_overflow_flag;

  control_polygon_segment_lengths i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow configuration and run state
  logic        m_rational, m_total_en;
  logic [15:0] m_first;
  logic signed [33:0] m_px, m_py, m_pz;
  logic        m_have_prev, m_prev_sat;
  logic [47:0] m_run_total;
  logic [15:0] m_seg_cnt;

  seg_t expected_segs[$];
  int   mismatches = 0;
  int   segs_seen = 0;
  int   poles_sent = 0;
  int   src_idle_pct = 0;
  int   snk_stall_pct = 0;
  bit   snk_hold = 1'b0;

  // in rational mode, coordinate divided by weight, truncating toward zero, saturated to int32; else passed through
  function automatic logic signed [33:0] project_coord(logic [31:0] c,
                                                       logic [31:0] w,
                                                       inout logic sat);
    logic signed [33:0] s;
    logic [32:0] mag;
    logic [63:0] q;
    s = $signed(c);
    if (!m_rational) return s;
    if (w == 0) begin
      sat = 1'b1;
      if (s > 0) return 34'sd2147483647;
      if (s < 0) return -34'sd2147483648;
      return '0;
    end
    mag = (s < 0) ? -s : s;
    q = {15'd0, mag, 16'd0} / {32'd0, w};
    if (s < 0) begin
      if (q > 64'h8000_0000) begin
        q = 64'h8000_0000;
        sat = 1'b1;
      end
      return -$signed({1'b0, q[32:0]});
    end
    if (q > 64'h7FFF_FFFF) begin
      q = 64'h7FFF_FFFF;
      sat = 1'b1;
    end
    return $signed({1'b0, q[32:0]});
  endfunction

  function automatic logic [33:0] root_floor(logic [67:0] v);
    logic [33:0] r;
    logic [33:0] c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      if ({34'd0, c} * {34'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  // advance the shadow state by one pole, queueing a segment if one results
  task automatic predict_segment(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                 logic [31:0] w, logic last);
    logic sat;
    logic signed [33:0] px, py, pz;
    logic [33:0] dx, dy, dz;
    logic [67:0] sq;
    logic [48:0] sum;
    seg_t s;
    sat = 1'b0;
    px = project_coord(x, w, sat);
    py = project_coord(y, w, sat);
    pz = project_coord(z, w, sat);
    if (m_have_prev) begin
      dx = (px > m_px) ? px - m_px : m_px - px;
      dy = (py > m_py) ? py - m_py : m_py - py;
      dz = (pz > m_pz) ? pz - m_pz : m_pz - pz;
      sq = {34'd0, dx} * {34'd0, dx} + {34'd0, dy} * {34'd0, dy}
         + {34'd0, dz} * {34'd0, dz};
      s.len = root_floor(sq);
      s.ovf = sat | m_prev_sat;
      s.tot = '0;
      if (m_total_en) begin
        sum = {1'b0, m_run_total} + {15'd0, s.len};
        if (sum[48]) begin
          sum = {1'b0, {48{1'b1}}};
          s.ovf = 1'b1;
        end
        m_run_total = sum[47:0];
        s.tot = sum[47:0];
      end
      s.idx = m_first + m_seg_cnt;
      s.fin = last;
      expected_segs.push_back(s);
      m_seg_cnt++;
    end
    m_px = px;
    m_py = py;
    m_pz = pz;
    m_prev_sat = sat;
    m_have_prev = 1'b1;
    if (last) begin
      m_have_prev = 1'b0;
      m_prev_sat = 1'b0;
      m_run_total = '0;
      m_seg_cnt = '0;
    end
  endtask

  // one pole transaction; valid held with stable payload until accepted
  task automatic send_pole(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [31:0] w, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    in_weight <= w;
    in_last_pole <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_segment(x, y, z, w, last);
    poles_sent++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_RATIONAL: m_rational = val[0];
      CFG_TOTAL:    m_total_en = val[0];
      CFG_FIRST:    m_first = val;
      default: ;
    endcase
  endtask

  // idle point: everything drained, then the block's worst-case pole time
  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (expected_segs.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  task automatic set_config(logic rat, logic tot, logic [15:0] first);
    drain();
    write_reg(CFG_RATIONAL, {15'd0, rat});
    write_reg(CFG_TOTAL, {15'd0, tot});
    write_reg(CFG_FIRST, first);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(32'h0004_0000);
      3: return -$urandom_range(32'h0004_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'h0001_0000;
      2: return $urandom_range(32'h0000_00FF, 1);
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // ---- result checking --------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seg_t got, exp_s;
      got = '{out_segment_index, out_segment_length, out_total_length,
              out_final_segment, out_overflow_flag};
      segs_seen++;
      if (expected_segs.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxErrShown)
          $display("unexpected segment transaction: %p", got);
      end else begin
        exp_s = expected_segs.pop_front();
        if (got !== exp_s) begin
          mismatches++;
          if (mismatches <= MaxErrShown)
            $display("segment mismatch: expected %p actual %p", exp_s, got);
        end
      end
    end
  end

  // receiver stalls; a hold-off forces the block to back up
  always @(posedge clk) begin
    out_ready <= !snk_hold && ($urandom_range(99) >= snk_stall_pct);
  end

  // ---- tests -------------------------------------------------------------
  task automatic test_directed();
    set_config(1'b0, 1'b1, 16'd0);
    send_pole(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);               // single pole run
    send_pole(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 1'b0);
    send_pole(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_pole(32'h0001_0000, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1);
    set_config(1'b1, 1'b1, 16'hFFFF);                           // index wraps
    send_pole(32'h0003_0000, 32'hFFFD_0000, 32'h0, 32'h0, 1'b0); // zero weight
    send_pole(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h1, 1'b0); // saturate
    send_pole(32'h0002_0000, 32'h0002_0000, 32'h0, 32'h0002_0000, 1'b0);
    send_pole(32'h8000_0000, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0);
    send_pole(32'h0, 32'h0, 32'h0, 32'h0001_0000, 1'b1);
    // maximal segments between opposite corners
    set_config(1'b0, 1'b1, 16'd5);
    for (int i = 0; i < 12; i++)
      send_pole(i[0] ? 32'h7FFF_FFFF : 32'h8000_0000, i[0] ? 32'h7FFF_FFFF
                : 32'h8000_0000, i[0] ? 32'h7FFF_FFFF : 32'h8000_0000, '0, i == 11);
    set_config(1'b1, 1'b0, 16'd0);
  endtask

  task automatic random_runs(int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      int run_len;
      run_len = ($urandom_range(9) == 0) ? 1 : $urandom_range(12, 2);
      for (int k = 0; k < run_len && sent < n; k++) begin
        send_pole(rand_coord(), rand_coord(), rand_coord(), rand_weight(),
                  k == run_len - 1);
        sent++;
      end
    end
  endtask

  task automatic test_random_phases();
    int pct_src[4] = '{0, 72, 0, 26};
    int pct_snk[4] = '{0, 0, 72, 26};
    for (int p = 0; p < 4; p++) begin
      set_config(1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom()));
      src_idle_pct = pct_src[p];
      snk_stall_pct = pct_snk[p];
      random_runs(200);
    end
  endtask

  // config changes between batches of poles, which may fall inside a run; extremes of first_index included
  task automatic test_config_sweep();
    logic [15:0] firsts[3] = '{16'd0, 16'hFFFF, 16'h8000};
    src_idle_pct = 10;
    snk_stall_pct = 10;
    for (int r = 0; r < 4; r++) begin
      for (int f = 0; f < 3; f++) begin
        set_config(r[0], r[1], firsts[f]);
        random_runs(8);
      end
    end
  endtask

  // receiver held off while poles keep coming, so input backs up
  task automatic test_backpressure();
    set_config(1'b0, 1'b1, 16'd100);
    src_idle_pct = 0;
    snk_stall_pct = 0;
    fork
      begin
        snk_hold = 1'b1;
        repeat (2000) @(posedge clk);
        snk_hold = 1'b0;
      end
      random_runs(40);
    join
  endtask

  initial begin
    m_rational = 1'b0;
    m_total_en = 1'b0;
    m_first = '0;
    m_px = '0;
    m_py = '0;
    m_pz = '0;
    m_have_prev = 1'b0;
    m_prev_sat = 1'b0;
    m_run_total = '0;
    m_seg_cnt = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_config_sweep();
    test_random_phases();
    drain();
    $display("covered %0d poles and %0d segments over all register settings,",
             poles_sent, segs_seen);
    $display("zero weights, saturation, index wrap and stall phases");
    if (mismatches == 0 && expected_segs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d segments missing", mismatches,
               expected_segs.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
